// ===== design/iur_pkg.sv =====
// Shared types, codes and helpers for the image upload receiver.
`default_nettype none
package iur_pkg;

  localparam int unsigned CHUNK_BYTES = 256;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QAW         = $clog2(QDEPTH);

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    C_DATA      = 4'd0,
    C_READY     = 4'd1,
    C_GO        = 4'd2,
    C_OK        = 4'd3,
    C_BAD_MAGIC = 4'd4,
    C_BAD_TYPE  = 4'd5,
    C_BAD_LEN   = 4'd6,
    C_BAD_CRC   = 4'd7,
    C_TIMEOUT   = 4'd8,
    C_BAD_IMAGE = 4'd9
  } code_t;

  typedef enum logic [2:0] {
    REG_HDR_MAGIC  = 3'd0,
    REG_SLOT_TYPE  = 3'd1,
    REG_IMG_MAGIC  = 3'd2,
    REG_WINDOW     = 3'd3,
    REG_HDR_IDLE   = 3'd4,
    REG_PAY_IDLE   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    code_t      code;
    logic [7:0] payload;
    logic       is_last;
  } result_t;

  // Up to two results per input item.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/iur_front.sv =====
// Front end: session, header and payload state; classifies each item into results.
`default_nettype none
module iur_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_kind,
  input  wire logic [7:0]        in_rx_byte,
  input  wire logic [31:0]       header_magic,
  input  wire logic [7:0]        slot_type,
  input  wire logic [31:0]       img_signature,
  input  wire logic [31:0]       header_window_ms,
  input  wire logic [15:0]       header_idle_ms,
  input  wire logic [15:0]       payload_idle_ms,
  output logic                   job_valid,
  output iur_pkg::job_t          job
);

  iur_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  hcnt_r, hcnt_nxt;
  logic [31:0] gmagic_r, gmagic_nxt;
  logic [7:0]  gtype_r, gtype_nxt;
  logic [31:0] glen_r, glen_nxt;
  logic [31:0] gcrc_r, gcrc_nxt;
  logic [31:0] pcnt_r, pcnt_nxt;
  logic [31:0] fword_r, fword_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [31:0] win_r, win_nxt;

  logic [31:0] pinc, fchunk, win_inc;
  logic [31:0] crc_new;
  logic        last_b;

  assign pinc    = pcnt_r + 32'd1;
  assign fchunk  = (glen_r < 32'(iur_pkg::CHUNK_BYTES)) ? glen_r : 32'(iur_pkg::CHUNK_BYTES);
  assign crc_new = iur_pkg::crc_byte(crc_r, in_rx_byte);
  assign last_b  = (pinc >= glen_r);
  assign win_inc = (win_r != 32'hFFFF_FFFF) ? win_r + 32'd1 : win_r;

  function automatic iur_pkg::result_t st(input iur_pkg::code_t c);
    iur_pkg::result_t r;
    r.code = c; r.payload = 8'd0; r.is_last = 1'b1;
    return r;
  endfunction

  always_comb begin
    phase_nxt = phase_r; hcnt_nxt = hcnt_r; gmagic_nxt = gmagic_r; gtype_nxt = gtype_r;
    glen_nxt = glen_r; gcrc_nxt = gcrc_r; pcnt_nxt = pcnt_r; fword_nxt = fword_r;
    crc_nxt = crc_r; idle_nxt = idle_r; win_nxt = win_r;
    job_valid = 1'b0;
    job = '0;
    if (in_valid) begin
      unique case (iur_pkg::kind_t'(in_kind))
        iur_pkg::KIND_START: begin
          win_nxt = '0; idle_nxt = '0; hcnt_nxt = '0; phase_nxt = iur_pkg::PH_HEADER;
          job_valid = 1'b1; job.r0 = st(iur_pkg::C_READY);
        end
        iur_pkg::KIND_BYTE: begin
          if (phase_r == iur_pkg::PH_HEADER) begin
            idle_nxt = '0;
            if (hcnt_r < 5'd4) gmagic_nxt = {in_rx_byte, gmagic_r[31:8]};
            else if (hcnt_r == 5'd4) gtype_nxt = in_rx_byte;
            else if (hcnt_r >= 5'd8 && hcnt_r < 5'd12) glen_nxt = {in_rx_byte, glen_r[31:8]};
            else if (hcnt_r >= 5'd12 && hcnt_r < 5'd16) gcrc_nxt = {in_rx_byte, gcrc_r[31:8]};
            hcnt_nxt = hcnt_r + 5'd1;
            if (hcnt_nxt >= 5'd16) begin
              job_valid = 1'b1;
              phase_nxt = iur_pkg::PH_IDLE;
              if (gmagic_nxt != header_magic) job.r0 = st(iur_pkg::C_BAD_MAGIC);
              else if (gtype_nxt != slot_type) job.r0 = st(iur_pkg::C_BAD_TYPE);
              else if (glen_nxt == 32'd0) job.r0 = st(iur_pkg::C_BAD_LEN);
              else begin
                phase_nxt = iur_pkg::PH_PAYLOAD; pcnt_nxt = '0; fword_nxt = '0;
                crc_nxt = iur_pkg::CRC_INIT; job.r0 = st(iur_pkg::C_GO);
              end
            end
          end else if (phase_r == iur_pkg::PH_PAYLOAD) begin
            idle_nxt = '0;
            if (pcnt_r < 32'd4) fword_nxt = {in_rx_byte, fword_r[31:8]};
            crc_nxt = crc_new;
            pcnt_nxt = pinc;
            job_valid = 1'b1;
            job.r0.code = iur_pkg::C_DATA; job.r0.payload = in_rx_byte; job.r0.is_last = last_b;
            if (pinc == fchunk && fchunk >= 32'd4 && fword_nxt != img_signature) begin
              phase_nxt = iur_pkg::PH_IDLE; job.two = 1'b1; job.r1 = st(iur_pkg::C_BAD_IMAGE);
            end else if (last_b) begin
              phase_nxt = iur_pkg::PH_IDLE; job.two = 1'b1;
              job.r1 = st(((crc_new ^ iur_pkg::CRC_INIT) == gcrc_r) ? iur_pkg::C_OK
                                                                     : iur_pkg::C_BAD_CRC);
            end
          end
        end
        iur_pkg::KIND_TICK: begin
          if (phase_r == iur_pkg::PH_HEADER) begin
            win_nxt = win_inc;
            if (idle_r < header_idle_ms) idle_nxt = idle_r + 16'd1;
            else begin
              job_valid = 1'b1;
              if (win_inc < header_window_ms) begin
                hcnt_nxt = '0; idle_nxt = '0; job.r0 = st(iur_pkg::C_READY);
              end else begin
                phase_nxt = iur_pkg::PH_IDLE; job.r0 = st(iur_pkg::C_TIMEOUT);
              end
            end
          end else if (phase_r == iur_pkg::PH_PAYLOAD) begin
            if (idle_r < payload_idle_ms) idle_nxt = idle_r + 16'd1;
            else begin
              job_valid = 1'b1; phase_nxt = iur_pkg::PH_IDLE; job.r0 = st(iur_pkg::C_TIMEOUT);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= iur_pkg::PH_IDLE; hcnt_r <= '0; gmagic_r <= '0; gtype_r <= '0;
      glen_r <= '0; gcrc_r <= '0; pcnt_r <= '0; fword_r <= '0;
      crc_r <= iur_pkg::CRC_INIT; idle_r <= '0; win_r <= '0;
    end else begin
      phase_r <= phase_nxt; hcnt_r <= hcnt_nxt; gmagic_r <= gmagic_nxt; gtype_r <= gtype_nxt;
      glen_r <= glen_nxt; gcrc_r <= gcrc_nxt; pcnt_r <= pcnt_nxt; fword_r <= fword_nxt;
      crc_r <= crc_nxt; idle_r <= idle_nxt; win_r <= win_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/iur_back.sv =====
// Back end: job queue and result sequencer that splits jobs into single results.
`default_nettype none
module iur_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  wire iur_pkg::job_t     job,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output iur_pkg::result_t       res
);

  iur_pkg::job_t q_r [iur_pkg::QDEPTH];
  logic [iur_pkg::QAW-1:0] wp_r, rp_r;
  logic [iur_pkg::QAW:0]   cnt_r;
  logic                    sub_r;   // second result of head job under way
  logic                    do_pop, head_done;
  iur_pkg::job_t           head;

  assign head      = q_r[rp_r];
  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == (iur_pkg::QAW+1)'(iur_pkg::QDEPTH));
  assign res       = sub_r ? head.r1 : head.r0;
  assign do_pop    = pop && !empty;
  assign head_done = do_pop && (sub_r || !head.two);

  always_ff @(posedge clk) begin
    if (job_valid && !full) q_r[wp_r] <= job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; sub_r <= 1'b0;
    end else begin
      if (job_valid && !full) wp_r <= wp_r + 1'b1;
      if (head_done) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (iur_pkg::QAW+1)'(job_valid && !full) - (iur_pkg::QAW+1)'(head_done);
      if (do_pop) sub_r <= !head_done;
    end
  end

endmodule
`default_nettype wire

// ===== design/image_upload_receiver.sv =====
// Top level of the image upload receiver: config registers, front end, result queue.
//
// Input channel: drive in_kind/in_rx_byte with in_push; a transfer happens when
// in_push is high and in_full is low. Kinds: start, received byte, 1 ms tick.
// Result channel: while out_empty is low, the oldest result sits on out_code,
// out_payload and out_is_last; it transfers when out_pop is high.
// Each input item is classified in its cycle of transfer and yields zero, one or
// two results, which are written into the job queue. One item per cycle is taken
// sustained as long as results are drained; an item giving two results holds its
// queue slot for two pops, so a stalled receiver fills the 4-entry job queue and
// in_full rises. Full is based on the queue count alone.
// Configuration: cfg_we with cfg_index and cfg_data writes register cfg_index
// at the clock edge; write only while idle.
// Reset (rst_n low, synchronous) restores the default registers, idles the
// session and empties the queue.
`default_nettype none
module image_upload_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [3:0]       out_code,
  output logic [7:0]       out_payload,
  output logic             out_is_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] header_magic_r, img_signature_r, header_window_r;
  logic [7:0]  slot_type_r;
  logic [15:0] header_idle_r, payload_idle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_magic_r  <= 32'h3149_5A52;
      slot_type_r     <= 8'd1;
      img_signature_r <= 32'h96F3_B83D;
      header_window_r <= 32'd30000;
      header_idle_r   <= 16'd1000;
      payload_idle_r  <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iur_pkg::REG_HDR_MAGIC: header_magic_r  <= cfg_data;
        iur_pkg::REG_SLOT_TYPE: slot_type_r     <= cfg_data[7:0];
        iur_pkg::REG_IMG_MAGIC: img_signature_r <= cfg_data;
        iur_pkg::REG_WINDOW:    header_window_r <= cfg_data;
        iur_pkg::REG_HDR_IDLE:  header_idle_r   <= cfg_data[15:0];
        iur_pkg::REG_PAY_IDLE:  payload_idle_r  <= cfg_data[15:0];
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  logic             job_valid;
  iur_pkg::job_t    job;
  iur_pkg::result_t res;

  // front only advances on an accepted transfer
  iur_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_push && !in_full), .in_kind(in_kind), .in_rx_byte(in_rx_byte),
    .header_magic(header_magic_r), .slot_type(slot_type_r),
    .img_signature(img_signature_r),
    .header_window_ms(header_window_r), .header_idle_ms(header_idle_r),
    .payload_idle_ms(payload_idle_r),
    .job_valid(job_valid), .job(job)
  );

  iur_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(job_valid), .job(job),
    .full(in_full), .empty(out_empty), .pop(out_pop), .res(res)
  );

  assign out_code    = res.code;
  assign out_payload = res.payload;
  assign out_is_last = res.is_last;

endmodule
`default_nettype wire

// ===== design/iur_checker.sv =====
// Port-level assertions for the image upload receiver, bound to the top level.
`default_nettype none
module iur_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_push,
  input wire logic       in_full,
  input wire logic [1:0] in_kind,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [3:0] out_code,
  input wire logic [7:0] out_payload,
  input wire logic       out_is_last
);
  // reset empties the queue
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty) else $error("not empty after reset");
  // a start transfer always leaves a result pending
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_kind == iur_pkg::KIND_START) |=> !out_empty)
    else $error("start gave no result");
  // status results are always last and carry no byte
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_code != iur_pkg::C_DATA) |-> (out_is_last && out_payload == 8'd0))
    else $error("bad status result");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_code) && $stable(out_payload)))
    else $error("result changed while stalled");
endmodule

bind image_upload_receiver iur_checker u_iur_checker (
  .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_kind(in_kind),
  .out_empty(out_empty), .out_pop(out_pop), .out_code(out_code),
  .out_payload(out_payload), .out_is_last(out_is_last)
);
`default_nettype wire
